// ===== design/rffsa_pkg.sv =====
// Shared types and constants of the row first-fit seat allocator.
// No dependencies; the ALU and the top level import it.
`default_nettype none
package rffsa_pkg;

  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 16;
  localparam int KW       = 26;
  localparam int RowOutW  = 10;
  localparam int SeatOutW = 16;
  localparam int NumRowsW = 11;

  localparam logic [CfgIdxW-1:0] CFG_NUM_ROWS  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_SEATS_ROW = 1'b1;

  typedef enum logic [1:0] {
    ALU_ADD  = 2'd0,
    ALU_SUB  = 2'd1,
    ALU_RSUB = 2'd2
  } alu_op_t;

  typedef enum logic [11:0] {
    ST_CLEAR = 12'b0000_0000_0001,
    ST_IDLE  = 12'b0000_0000_0010,
    ST_G_RD  = 12'b0000_0000_0100,
    ST_G_CHK = 12'b0000_0000_1000,
    ST_S_RD  = 12'b0000_0001_0000,
    ST_S_ACC = 12'b0000_0010_0000,
    ST_S_CMP = 12'b0000_0100_0000,
    ST_D_RD  = 12'b0000_1000_0000,
    ST_D_WR  = 12'b0001_0000_0000,
    ST_A_RD  = 12'b0010_0000_0000,
    ST_A_CHK = 12'b0100_0000_0000,
    ST_DONE  = 12'b1000_0000_0000
  } state_t;

endpackage
`default_nettype wire

// ===== design/rffsa_alu.sv =====
// Shared add, subtract and compare unit of the seat allocator.
// Depends on rffsa_pkg for the operation codes.
`default_nettype none
module rffsa_alu
  import rffsa_pkg::*;
#(
  parameter int W = 32
) (
  input  wire alu_op_t      op,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic [W-1:0]      y,
  output logic              ge
);

  assign ge = (a >= b);

  always_comb begin
    case (op)
      ALU_ADD:  y = a + b;
      ALU_SUB:  y = a - b;
      ALU_RSUB: y = b - a;
      default:  y = a - b;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/row_first_fit_seat_allocator_top.sv =====
// Channel  | Signals                                  | Contents
// s_*      | s_tvalid s_tready s_tdata s_tuser        | seat request
// m_*      | m_tvalid m_tready m_tdata m_tuser        | grant result
// cfg_*    | cfg_valid cfg_ready cfg_index cfg_data   | register writes
// A request walks the rows one at a time through a row memory with one read and one
// write port, each row visited in a read state and then a check or update state, plus a
// sum pass and a drain pass for scatters and a walk past emptied rows; the memory sets the rate.
// The idle state takes the request and the done state loads the result.
// After reset and after every register write a clearing pass over all MAX_ROWS rows refills
// the rows while s_tready is low. A result waits in the output register while the next
// request is taken.
// Top level of the seat allocator; depends on rffsa_pkg and rffsa_alu.
`default_nettype none
module row_first_fit_seat_allocator_top
  import rffsa_pkg::*;
#(
  parameter int MAX_ROWS  = 1024,
  parameter int SEAT_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [39:0]         s_tdata,   // seat_count[25:0], max_row[35:26], zero
  input  wire logic                s_tuser,   // req_type
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [31:0]              m_tdata,   // seat_row[9:0], seat_index[25:10], zero
  output logic                     m_tuser,   // granted
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int RB = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = (RB + 1 > NumRowsW) ? RB + 1 : NumRowsW;
  localparam int SB = SEAT_BITS;
  localparam int AW = (SB + RB + 1 > KW) ? SB + RB + 1 : KW;

  state_t state;
  logic [NumRowsW-1:0] num_rows;
  logic [SB-1:0]       spr;
  logic [CW-1:0]       fo, r, maxr, clr_cnt, n_rows;
  logic [AW-1:0]       k_rem, total;
  logic                req_scatter;
  logic                res_granted;
  logic [CW-1:0]       res_row;
  logic [SB-1:0]       res_seat;
  logic [SB-1:0]       mem [MAX_ROWS];
  logic [SB-1:0]       rd_data;
  logic [RB-1:0]       rd_addr;
  logic                we;
  logic [RB-1:0]       waddr;
  logic [SB-1:0]       wdata;
  alu_op_t             op;
  logic [AW-1:0]       alu_a, alu_b, alu_y;
  logic                alu_ge;
  logic [AW-1:0]       rd_ext;
  logic [CW-1:0]       req_maxr, max_row_ext, n_last;
  logic [47:0]         cfg_ext, seat_diff_ext;
  logic [CW+RowOutW-1:0] row_ext;
  logic [SB-1:0]       seat_diff;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_ext   = {32'd0, cfg_data};
  assign rd_ext    = AW'(rd_data);

  always_comb begin
    if (num_rows == '0) begin
      n_rows = CW'(1);
    end else if (CW'(num_rows) > CW'(MAX_ROWS)) begin
      n_rows = CW'(MAX_ROWS);
    end else begin
      n_rows = CW'(num_rows);
    end
    n_last      = n_rows - CW'(1);
    max_row_ext = CW'(s_tdata[35:26]);
    req_maxr    = (max_row_ext > n_last) ? n_last : max_row_ext;
  end

  rffsa_alu #(.W(AW)) u_alu (
    .op (op),
    .a  (alu_a),
    .b  (alu_b),
    .y  (alu_y),
    .ge (alu_ge)
  );

  always_comb begin
    op    = ALU_SUB;
    alu_a = rd_ext;
    alu_b = k_rem;
    case (state)
      ST_S_ACC: begin
        op    = ALU_ADD;
        alu_a = total;
        alu_b = rd_ext;
      end
      ST_S_CMP: begin
        alu_a = total;
        alu_b = k_rem;
      end
      ST_D_WR: begin
        alu_a = k_rem;
        alu_b = rd_ext;
        op    = alu_ge ? ALU_SUB : ALU_RSUB;
      end
      default: begin
        op = ALU_SUB;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = r[RB-1:0];
    wdata = alu_y[SB-1:0];
    rd_addr = r[RB-1:0];
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_cnt[RB-1:0];
        wdata = spr;
      end
      ST_G_CHK: begin
        we = alu_ge;
      end
      ST_D_WR: begin
        we    = 1'b1;
        wdata = alu_ge ? '0 : alu_y[SB-1:0];
      end
      ST_A_RD: begin
        rd_addr = fo[RB-1:0];
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  assign seat_diff     = spr - rd_data;
  assign seat_diff_ext = 48'(seat_diff);
  assign row_ext       = (CW + RowOutW)'(r);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      num_rows <= NumRowsW'(1024);
      spr      <= SB'(17'd65535);
      fo       <= '0;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_NUM_ROWS) begin
          num_rows <= cfg_data[NumRowsW-1:0];
        end else begin
          spr <= cfg_ext[SB-1:0];
        end
        fo      <= '0;
        clr_cnt <= '0;
        state   <= ST_CLEAR;
      end else begin
        case (state)
          ST_CLEAR: begin
            clr_cnt <= clr_cnt + CW'(1);
            if (clr_cnt == CW'(MAX_ROWS - 1)) begin
              state <= ST_IDLE;
            end
          end
          ST_IDLE: begin
            if (s_tvalid) begin
              k_rem       <= AW'(s_tdata[25:0]);
              maxr        <= req_maxr;
              r           <= fo;
              total       <= '0;
              req_scatter <= s_tuser;
              res_granted <= 1'b0;
              res_row     <= '0;
              res_seat    <= '0;
              if (fo > req_maxr) begin
                state <= ST_DONE;
              end else if (s_tuser) begin
                state <= ST_S_RD;
              end else begin
                state <= ST_G_RD;
              end
            end
          end
          ST_G_RD: state <= ST_G_CHK;
          ST_G_CHK: begin
            if (alu_ge) begin
              res_granted <= 1'b1;
              res_row     <= r;
              res_seat    <= seat_diff;
              state       <= ST_A_RD;
            end else if (r == maxr) begin
              state <= ST_DONE;
            end else begin
              r     <= r + CW'(1);
              state <= ST_G_RD;
            end
          end
          ST_S_RD: state <= ST_S_ACC;
          ST_S_ACC: begin
            total <= alu_y;
            if (r == maxr) begin
              state <= ST_S_CMP;
            end else begin
              r     <= r + CW'(1);
              state <= ST_S_RD;
            end
          end
          ST_S_CMP: begin
            r <= fo;
            if (!alu_ge) begin
              state <= ST_DONE;
            end else begin
              res_granted <= 1'b1;
              state       <= (k_rem == '0) ? ST_A_RD : ST_D_RD;
            end
          end
          ST_D_RD: state <= ST_D_WR;
          ST_D_WR: begin
            k_rem <= alu_ge ? alu_y : '0;
            if (!alu_ge || alu_y == '0 || r == maxr) begin
              state <= ST_A_RD;
            end else begin
              r     <= r + CW'(1);
              state <= ST_D_RD;
            end
          end
          ST_A_RD: begin
            state <= (fo >= n_rows) ? ST_DONE : ST_A_CHK;
          end
          ST_A_CHK: begin
            if (rd_data == '0) begin
              fo    <= fo + CW'(1);
              state <= ST_A_RD;
            end else begin
              state <= ST_DONE;
            end
          end
          ST_DONE: begin
            if (!m_tvalid || m_tready) begin
              state <= ST_IDLE;
            end
          end
          default: state <= ST_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tuser <= res_granted;
      m_tdata <= {6'd0, res_seat_out(res_seat), res_row_out(res_row)};
    end
  end

  function automatic logic [SeatOutW-1:0] res_seat_out(input logic [SB-1:0] v);
    logic [47:0] t;
    t = 48'(v);
    return t[SeatOutW-1:0];
  endfunction

  function automatic logic [RowOutW-1:0] res_row_out(input logic [CW-1:0] v);
    logic [CW+RowOutW-1:0] t;
    t = (CW + RowOutW)'(v);
    return t[RowOutW-1:0];
  endfunction

  logic unused_ok;
  assign unused_ok = ^{seat_diff_ext, row_ext, req_scatter, s_tdata[39:36]};

endmodule
`default_nettype wire

// ===== design/rffsa_check.sv =====
// Port-level checks of the seat allocator and their binding to the top level.
// Depends on rffsa_pkg for the configuration port widths.
`default_nettype none
module rffsa_check
  import rffsa_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst,
  input wire logic                s_tvalid,
  input wire logic                s_tready,
  input wire logic [39:0]         s_tdata,
  input wire logic                s_tuser,
  input wire logic                m_tvalid,
  input wire logic                m_tready,
  input wire logic [31:0]         m_tdata,
  input wire logic                m_tuser,
  input wire logic                cfg_valid,
  input wire logic                cfg_ready,
  input wire logic [CfgIdxW-1:0]  cfg_index,
  input wire logic [CfgDataW-1:0] cfg_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_deny_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == 32'd0)
    else $error("denied request carries data");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("request taken before rows are refilled");

  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> !s_tready)
    else $error("request taken during refill");

  a_one_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !cfg_valid |=> !s_tready)
    else $error("second request taken while one is in work");

endmodule

bind row_first_fit_seat_allocator_top rffsa_check u_rffsa_check (.*);
`default_nettype wire
